### rtl/mcsg_pkg.sv
// ----------------------------------------------------------------------------
// mcsg_pkg
// Types, codes and reset values shared by the motor command safety gate.
// ----------------------------------------------------------------------------
package mcsg_pkg;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned FRAME_W   = 64;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [2:0] FUNC_FEEDBACK = 3'd0;
    localparam logic [2:0] FUNC_STAGE    = 3'd1;
    localparam logic [2:0] FUNC_ARM      = 3'd2;
    localparam logic [2:0] FUNC_STOP     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;
    localparam logic [2:0] FUNC_SNAPSHOT = 3'd5;
    localparam logic [2:0] FUNC_QUERY    = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NOTSUP   = 3'd2;
    localparam logic [2:0] ST_DENIED   = 3'd3;
    localparam logic [2:0] ST_LINKDOWN = 3'd4;
    localparam logic [2:0] ST_STALE    = 3'd5;
    localparam logic [2:0] ST_BUSY     = 3'd6;

    localparam logic [1:0] MOTOR_OFFLINE = 2'd0;
    localparam logic [1:0] MOTOR_FAULT   = 2'd1;
    localparam logic [1:0] MOTOR_READY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT  = 2'd2;

    localparam logic [MODE_W-1:0] RST_CONTROL_MODE = 2'd0;
    localparam logic [TMO_W-1:0]  RST_FB_TIMEOUT   = 16'd100;
    localparam logic [TMO_W-1:0]  RST_CMD_TIMEOUT  = 16'd50;

    typedef struct packed {
        logic [2:0]         func;
        logic [TIME_W-1:0]  now_ms;
        logic               fb_fault;
        logic               fb_disabled;
        logic [MODE_W-1:0]  cmd_mode;
        logic [EPOCH_W-1:0] epoch;
        logic [FRAME_W-1:0] payload;
        logic               latch_request;
        logic [TIME_W-1:0]  recovery_start_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] frame_out;
        logic [1:0]         motor_state;
        logic               recovery_ready;
    } t_out_item;

    typedef struct packed {
        logic [MODE_W-1:0] control_mode;
        logic [TMO_W-1:0]  feedback_timeout_ms;
        logic [TMO_W-1:0]  command_timeout_ms;
    } t_cfg;

endpackage

### rtl/mcsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcsg_cfg_regs
// Configuration registers: control mode and the two timeouts.
// ----------------------------------------------------------------------------
module mcsg_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcsg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mcsg_pkg::t_cfg                    o_cfg
);
    import mcsg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control_mode        <= RST_CONTROL_MODE;
            r_cfg.feedback_timeout_ms <= RST_FB_TIMEOUT;
            r_cfg.command_timeout_ms  <= RST_CMD_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CONTROL_MODE: r_cfg.control_mode        <= i_cfg_data[MODE_W-1:0];
                CFG_FB_TIMEOUT:   r_cfg.feedback_timeout_ms <= i_cfg_data[TMO_W-1:0];
                CFG_CMD_TIMEOUT:  r_cfg.command_timeout_ms  <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/mcsg_core.sv
// ----------------------------------------------------------------------------
// mcsg_core
// Gate state and per-event decision logic; state advances on each fired item.
// ----------------------------------------------------------------------------
module mcsg_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mcsg_pkg::t_in_item  i_item,
    input  mcsg_pkg::t_cfg      i_cfg,
    output mcsg_pkg::t_out_item o_result
);
    import mcsg_pkg::*;

    logic [TIME_W-1:0]  r_last_fb_ms,   n_last_fb_ms;
    logic               r_drive_fault,  n_drive_fault;
    logic               r_drive_dis,    n_drive_dis;
    logic               r_fault_hold,   n_fault_hold;
    logic               r_armed,        n_armed;
    logic [EPOCH_W-1:0] r_arm_epoch,    n_arm_epoch;
    logic [EPOCH_W-1:0] r_cmd_epoch,    n_cmd_epoch;
    logic [TIME_W-1:0]  r_cmd_stamp_ms, n_cmd_stamp_ms;
    logic               r_cmd_valid,    n_cmd_valid;
    logic [FRAME_W-1:0] r_cmd_frame,    n_cmd_frame;

    logic [TIME_W:0] fb_age;
    logic [TIME_W:0] cmd_age;
    logic            fresh;
    logic            cmd_young;
    logic            any_fault;
    t_out_item       res;

    assign fb_age  = {1'b0, i_item.now_ms} - {1'b0, r_last_fb_ms};
    assign cmd_age = {1'b0, i_item.now_ms} - {1'b0, r_cmd_stamp_ms};
    assign fresh = (r_last_fb_ms != '0) && !fb_age[TIME_W] &&
                   (fb_age[TIME_W-1:0] <= {{(TIME_W-TMO_W){1'b0}}, i_cfg.feedback_timeout_ms});
    assign cmd_young = (r_cmd_stamp_ms != '0) && !cmd_age[TIME_W] &&
                   (cmd_age[TIME_W-1:0] <= {{(TIME_W-TMO_W){1'b0}}, i_cfg.command_timeout_ms});
    assign any_fault = r_fault_hold || r_drive_fault;

    always_comb begin
        n_last_fb_ms    = r_last_fb_ms;
        n_drive_fault   = r_drive_fault;
        n_drive_dis     = r_drive_dis;
        n_fault_hold    = r_fault_hold;
        n_armed         = r_armed;
        n_arm_epoch     = r_arm_epoch;
        n_cmd_epoch     = r_cmd_epoch;
        n_cmd_stamp_ms  = r_cmd_stamp_ms;
        n_cmd_valid     = r_cmd_valid;
        n_cmd_frame     = r_cmd_frame;
        res             = '0;
        res.status      = ST_OK;
        unique case (i_item.func)
            FUNC_FEEDBACK: begin
                if (i_item.now_ms == '0) begin
                    res.status = ST_INVALID;
                end else begin
                    n_drive_fault = i_item.fb_fault;
                    n_drive_dis   = i_item.fb_disabled && !i_item.fb_fault;
                    n_last_fb_ms  = i_item.now_ms;
                    if (i_item.fb_fault) begin
                        n_fault_hold = 1'b1;
                        n_armed      = 1'b0;
                        n_arm_epoch  = '0;
                        n_cmd_valid  = 1'b0;
                    end
                end
            end
            FUNC_STAGE: begin
                if (i_item.cmd_mode != i_cfg.control_mode) begin
                    res.status = ST_NOTSUP;
                end else if (!r_armed || r_arm_epoch == '0) begin
                    res.status = ST_DENIED;
                end else if (any_fault || !fresh) begin
                    res.status = ST_LINKDOWN;
                end else begin
                    n_cmd_frame    = i_item.payload;
                    n_cmd_stamp_ms = i_item.now_ms;
                    n_cmd_epoch    = r_arm_epoch;
                    n_cmd_valid    = 1'b1;
                end
            end
            FUNC_ARM: begin
                if (i_item.epoch == '0 || i_item.now_ms == '0) begin
                    res.status = ST_INVALID;
                end else begin
                    n_cmd_frame    = i_item.payload;
                    n_cmd_stamp_ms = i_item.now_ms;
                    n_cmd_epoch    = i_item.epoch;
                    n_arm_epoch    = i_item.epoch;
                    n_cmd_valid    = 1'b1;
                    n_armed        = 1'b1;
                end
            end
            FUNC_STOP: begin
                n_armed        = 1'b0;
                n_arm_epoch    = '0;
                n_cmd_epoch    = '0;
                n_cmd_stamp_ms = '0;
                n_cmd_valid    = 1'b0;
                if (i_item.latch_request) begin
                    n_fault_hold = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_fault_hold = 1'b0;
                n_armed      = 1'b0;
                n_arm_epoch  = '0;
            end
            FUNC_SNAPSHOT: begin
                if (i_item.epoch == '0) begin
                    res.status = ST_INVALID;
                end else if (!r_armed || any_fault) begin
                    res.status = ST_DENIED;
                end else if (!r_cmd_valid || r_arm_epoch != i_item.epoch ||
                             r_cmd_epoch != i_item.epoch) begin
                    res.status = ST_STALE;
                end else if (!fresh) begin
                    res.status = ST_LINKDOWN;
                end else if (!cmd_young) begin
                    res.status = ST_STALE;
                end else begin
                    res.frame_out = r_cmd_frame;
                end
            end
            FUNC_QUERY: begin
                if (any_fault || !fresh) begin
                    res.status = ST_LINKDOWN;
                end else if (!r_drive_dis) begin
                    res.status = ST_BUSY;
                end
                if (r_last_fb_ms == '0) begin
                    res.motor_state = MOTOR_OFFLINE;
                end else if (any_fault) begin
                    res.motor_state = MOTOR_FAULT;
                end else if (fresh) begin
                    res.motor_state = MOTOR_READY;
                end else begin
                    res.motor_state = MOTOR_OFFLINE;
                end
                res.recovery_ready = (i_item.recovery_start_ms != '0) && fresh &&
                                     (r_last_fb_ms > i_item.recovery_start_ms) &&
                                     r_drive_dis;
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fb_ms    <= '0;
            r_drive_fault   <= 1'b0;
            r_drive_dis     <= 1'b0;
            r_fault_hold    <= 1'b0;
            r_armed         <= 1'b0;
            r_arm_epoch     <= '0;
            r_cmd_epoch     <= '0;
            r_cmd_stamp_ms  <= '0;
            r_cmd_valid     <= 1'b0;
            r_cmd_frame     <= '0;
        end else if (i_fire) begin
            r_last_fb_ms    <= n_last_fb_ms;
            r_drive_fault   <= n_drive_fault;
            r_drive_dis     <= n_drive_dis;
            r_fault_hold    <= n_fault_hold;
            r_armed         <= n_armed;
            r_arm_epoch     <= n_arm_epoch;
            r_cmd_epoch     <= n_cmd_epoch;
            r_cmd_stamp_ms  <= n_cmd_stamp_ms;
            r_cmd_valid     <= n_cmd_valid;
            r_cmd_frame     <= n_cmd_frame;
        end
    end

    assign o_result = res;

endmodule

### rtl/motor_command_safety_gate.sv
// ----------------------------------------------------------------------------
// motor_command_safety_gate
// Safety gate for a motor driven by periodic command frames.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one event per
// item: feedback, stage, arm, stop, clear fault, snapshot or query, each
// stamped with the current time. Output channel (o_out_valid / i_out_stall /
// o_out_item) returns exactly one result item per event, in order.
// An item lands in an input register, is decided combinationally against the
// gate state, and its result is held in an output register, which raises
// o_out_valid; throughput one item per cycle while the receiver does not stall.
// While the receiver stalls, the result holds and the input register fills;
// o_in_stall rises once both are occupied, and nothing is lost.
// Configuration writes (i_cfg_we / i_cfg_index / i_cfg_data) take effect at
// the next edge. Synchronous reset restores register defaults (mode 0,
// feedback timeout 100, command timeout 50), disarms, clears faults and
// feedback history, and empties both pipeline registers.
// ----------------------------------------------------------------------------
module motor_command_safety_gate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mcsg_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mcsg_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [mcsg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcsg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mcsg_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      advance;
    logic      take_in;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    mcsg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mcsg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
